// ===== hw/rtl/fipf_pkg.sv =====
// Shared types, constants and helpers for the firmware image packet framer.
// No dependencies; every framer file but fipf_if refers to it by scoped name.
`default_nettype none

package fipf_pkg;

	// Image bytes per full packet (a power of two)
	localparam int PAYLOAD_BYTES = 512;
	// Width that holds a payload length or position, up to and including PAYLOAD_BYTES
	localparam int LEN_W = $clog2(PAYLOAD_BYTES + 1);

	// Frame constants
	localparam logic [7:0] START_SYNC  = 8'h68;
	localparam logic [7:0] PKT_SYNC    = 8'h6b;
	localparam logic [7:0] FRAME_MARK  = 8'h5a;
	localparam logic [7:0] START_KIND  = 8'h0c;

	// Segment lengths in bytes
	localparam int START_BYTES = 20;
	localparam int HDR_BYTES   = 10;
	localparam int TRL_BYTES   = 4;
	localparam int CNT_W       = $clog2(START_BYTES);

	// Job queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam logic [APB_ADDR_W-1:0] ADDR_IMAGE_SIZE = 3'd0;

	// One classified request, as the back end expands it
	typedef struct packed {
		logic             is_start;
		logic [30:0]      size;
		logic             hdr_en;
		logic [LEN_W-1:0] len;
		logic [31:0]      idx;
		logic             data_en;
		logic [7:0]       data;
		logic             trl_en;
		logic [31:0]      trl_sum;
		logic             emp_en;
		logic [31:0]      emp_idx;
	} fipf_job_t;

	// Sum of the four bytes of a word
	function automatic logic [9:0] byte_sum32(input logic [31:0] v);
		byte_sum32 = 10'(v[7:0]) + 10'(v[15:8]) + 10'(v[23:16]) + 10'(v[31:24]);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fipf_if.sv =====
// Valid/ready channel interfaces for the framer's request input and byte output.
// Depends on nothing.
`default_nettype none

interface fipf_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] image_byte;

	modport source (output valid, req_type, image_byte, input ready);
	modport sink   (input valid, req_type, image_byte, output ready);
endinterface

interface fipf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;
	logic       run_last;

	modport source (output valid, out_byte, frame_end, run_last, input ready);
	modport sink   (input valid, out_byte, frame_end, run_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fipf_front.sv =====
// Front end: takes requests, tracks framing and emits at most one job per request.
// Depends on fipf_pkg and fipf_if.
`default_nettype none

module fipf_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	fipf_req_if.sink                items,
	input  wire logic [30:0]        image_size,
	input  wire logic               q_full,
	output logic                    push,
	output fipf_pkg::fipf_job_t     job
);

	logic [30:0]                bt_q;
	logic [31:0]                pn_q;
	logic [fipf_pkg::LEN_W-1:0] pos_q;
	logic [31:0]                rs_q;

	logic                       accept;
	logic                       at_end;
	logic                       first_empty;
	logic [30:0]                remaining;
	logic [31:0]                span;
	logic [fipf_pkg::LEN_W-1:0] len;
	logic [fipf_pkg::LEN_W-1:0] pos_inc;
	logic                       pkt_done;
	logic [31:0]                seed;
	logic [31:0]                sum_new;
	logic [30:0]                bt_inc;
	logic [31:0]                pn_inc;
	logic                       exact;

	assign items.ready = !q_full;
	assign accept      = items.valid && items.ready;

	// Packet length and completion for the current byte
	assign at_end      = bt_q >= image_size;
	assign first_empty = (image_size == '0) && (bt_q == '0) && (pn_q == '0) && (pos_q == '0);
	assign remaining   = image_size - bt_q;
	assign span        = 32'(pos_q) + {1'b0, remaining};
	assign len         = (span > 32'(fipf_pkg::PAYLOAD_BYTES)) ?
		fipf_pkg::LEN_W'(fipf_pkg::PAYLOAD_BYTES) : span[fipf_pkg::LEN_W-1:0];
	assign pos_inc     = pos_q + 1'b1;
	assign pkt_done    = pos_inc >= len;
	assign bt_inc      = bt_q + 1'b1;
	assign pn_inc      = pn_q + 1'b1;
	assign exact       = (len == fipf_pkg::LEN_W'(fipf_pkg::PAYLOAD_BYTES)) &&
		(bt_inc == image_size);

	// Checksum: the header seeds it with the index byte sum
	assign seed    = (pos_q == '0) ? 32'(fipf_pkg::byte_sum32(pn_q)) : rs_q;
	assign sum_new = seed + 32'(items.image_byte);

	// Classify the request into a job
	always_comb begin
		job     = '0;
		push    = 1'b0;
		if (!items.req_type) begin
			job.is_start = 1'b1;
			job.size     = image_size;
			push         = accept;
		end else if (at_end) begin
			job.emp_en  = 1'b1;
			job.emp_idx = pn_q;
			push        = accept && first_empty;
		end else begin
			job.hdr_en  = pos_q == '0;
			job.len     = len;
			job.idx     = pn_q;
			job.data_en = 1'b1;
			job.data    = items.image_byte;
			job.trl_en  = pkt_done;
			job.trl_sum = sum_new;
			job.emp_en  = pkt_done && exact;
			job.emp_idx = pn_inc;
			push        = accept;
		end
	end

	// Framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bt_q  <= '0;
			pn_q  <= '0;
			pos_q <= '0;
			rs_q  <= '0;
		end else if (accept) begin
			if (!items.req_type) begin
				bt_q  <= '0;
				pn_q  <= '0;
				pos_q <= '0;
				rs_q  <= '0;
			end else if (at_end) begin
				if (first_empty) begin
					pn_q <= pn_inc;
				end
			end else begin
				bt_q <= bt_inc;
				if (pkt_done) begin
					pos_q <= '0;
					rs_q  <= '0;
					pn_q  <= exact ? (pn_q + 32'd2) : pn_inc;
				end else begin
					pos_q <= pos_inc;
					rs_q  <= sum_new;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fipf_queue.sv =====
// Short job queue that decouples the framer's front and back ends.
// Depends on fipf_pkg.
`default_nettype none

module fipf_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire fipf_pkg::fipf_job_t wr_job,
	input  wire logic                pop,
	output fipf_pkg::fipf_job_t      head,
	output logic                     empty,
	output logic                     full
);

	localparam int PTR_W = $clog2(fipf_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(fipf_pkg::QUEUE_DEPTH + 1);

	fipf_pkg::fipf_job_t entry_q [fipf_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = count_q == '0;
	assign full  = count_q == CNT_W'(fipf_pkg::QUEUE_DEPTH);
	assign head  = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(fipf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(fipf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fipf_back.sv =====
// Back end: expands queued jobs into framed bytes, one per cycle unless stalled.
// Depends on fipf_pkg and fipf_if.
`default_nettype none

module fipf_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_empty,
	input  wire fipf_pkg::fipf_job_t head,
	output logic                     pop,
	fipf_out_if.source               frames
);

	typedef enum logic [5:0] {
		SEG_START = 6'b000001,
		SEG_HDR   = 6'b000010,
		SEG_DATA  = 6'b000100,
		SEG_TRL   = 6'b001000,
		SEG_EHDR  = 6'b010000,
		SEG_ETRL  = 6'b100000
	} fipf_seg_t;

	fipf_seg_t                  seg_q;
	logic                       busy_q;
	logic [fipf_pkg::CNT_W-1:0] cnt_q;
	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic                       frame_end_q;
	logic                       run_last_q;

	fipf_seg_t                  first_seg;
	fipf_seg_t                  cur_seg;
	fipf_seg_t                  nxt_seg;
	logic [fipf_pkg::CNT_W-1:0] cnt;
	logic                       seg_last;
	logic                       no_next;
	logic                       job_last;
	logic                       adv;
	logic [7:0]                 byte_val;
	logic                       end_val;
	logic [31:0]                total;
	logic [31:0]                start_sum;
	logic [31:0]                emp_sum;
	logic [15:0]                len16;

	function automatic logic [7:0] le_byte(input logic [31:0] v, input logic [1:0] k);
		case (k)
			2'd0:    le_byte = v[7:0];
			2'd1:    le_byte = v[15:8];
			2'd2:    le_byte = v[23:16];
			default: le_byte = v[31:24];
		endcase
	endfunction

	// Derived words of the start frame and the empty packet
	assign total     = ({1'b0, head.size} / fipf_pkg::PAYLOAD_BYTES) + 32'd1;
	assign start_sum = 32'(fipf_pkg::START_SYNC) + 32'(fipf_pkg::FRAME_MARK) +
		32'(fipf_pkg::START_KIND) + 32'(fipf_pkg::byte_sum32({1'b0, head.size})) +
		32'(fipf_pkg::byte_sum32(total));
	assign emp_sum   = 32'(fipf_pkg::byte_sum32(head.emp_idx));
	assign len16     = 16'(head.len);

	// Segment at which a fresh job begins
	always_comb begin
		if (head.is_start) begin
			first_seg = SEG_START;
		end else if (head.hdr_en) begin
			first_seg = SEG_HDR;
		end else if (head.data_en) begin
			first_seg = SEG_DATA;
		end else begin
			first_seg = SEG_EHDR;
		end
	end

	assign cur_seg = busy_q ? seg_q : first_seg;
	assign cnt     = busy_q ? cnt_q : '0;

	// Segment sequencing
	always_comb begin
		seg_last = 1'b0;
		no_next  = 1'b1;
		nxt_seg  = SEG_START;
		unique case (cur_seg)
			SEG_START: begin
				seg_last = cnt == fipf_pkg::CNT_W'(fipf_pkg::START_BYTES - 1);
			end
			SEG_HDR: begin
				seg_last = cnt == fipf_pkg::CNT_W'(fipf_pkg::HDR_BYTES - 1);
				no_next  = 1'b0;
				nxt_seg  = SEG_DATA;
			end
			SEG_DATA: begin
				seg_last = 1'b1;
				no_next  = !head.trl_en;
				nxt_seg  = SEG_TRL;
			end
			SEG_TRL: begin
				seg_last = cnt == fipf_pkg::CNT_W'(fipf_pkg::TRL_BYTES - 1);
				no_next  = !head.emp_en;
				nxt_seg  = SEG_EHDR;
			end
			SEG_EHDR: begin
				seg_last = cnt == fipf_pkg::CNT_W'(fipf_pkg::HDR_BYTES - 1);
				no_next  = 1'b0;
				nxt_seg  = SEG_ETRL;
			end
			SEG_ETRL: begin
				seg_last = cnt == fipf_pkg::CNT_W'(fipf_pkg::TRL_BYTES - 1);
			end
			default: begin
				seg_last = 1'b1;
			end
		endcase
	end

	assign job_last = seg_last && no_next;
	assign adv      = !q_empty && (!out_valid_q || frames.ready);
	assign pop      = adv && job_last;

	// Byte selection
	always_comb begin
		byte_val = 8'h00;
		end_val  = 1'b0;
		unique case (cur_seg) inside
			SEG_START: begin
				end_val = seg_last;
				case (cnt) inside
					5'd0:            byte_val = fipf_pkg::START_SYNC;
					5'd1:            byte_val = fipf_pkg::FRAME_MARK;
					5'd2:            byte_val = fipf_pkg::START_KIND;
					[5'd4:5'd7]:     byte_val = le_byte({1'b0, head.size}, cnt[1:0]);
					[5'd8:5'd11]:    byte_val = le_byte(total, cnt[1:0]);
					[5'd16:5'd19]:   byte_val = le_byte(start_sum, cnt[1:0]);
					default:         byte_val = 8'h00;
				endcase
			end
			SEG_HDR, SEG_EHDR: begin
				case (cnt) inside
					5'd0: byte_val = fipf_pkg::PKT_SYNC;
					5'd1: byte_val = fipf_pkg::FRAME_MARK;
					5'd2: byte_val = (cur_seg == SEG_HDR) ? len16[7:0] : 8'h00;
					5'd3: byte_val = (cur_seg == SEG_HDR) ? len16[15:8] : 8'h00;
					[5'd6:5'd9]: begin
						byte_val = le_byte((cur_seg == SEG_HDR) ? head.idx : head.emp_idx,
							cnt[1:0] + 2'd2);
					end
					default: byte_val = 8'h00;
				endcase
			end
			SEG_DATA: begin
				byte_val = head.data;
			end
			SEG_TRL: begin
				byte_val = le_byte(head.trl_sum, cnt[1:0]);
				end_val  = seg_last;
			end
			SEG_ETRL: begin
				byte_val = le_byte(emp_sum, cnt[1:0]);
				end_val  = seg_last;
			end
			default: begin
				byte_val = 8'h00;
			end
		endcase
	end

	// Sequencer position within the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			seg_q  <= SEG_START;
			cnt_q  <= '0;
		end else if (adv) begin
			if (job_last) begin
				busy_q <= 1'b0;
				cnt_q  <= '0;
			end else if (seg_last) begin
				busy_q <= 1'b1;
				seg_q  <= nxt_seg;
				cnt_q  <= '0;
			end else begin
				busy_q <= 1'b1;
				seg_q  <= cur_seg;
				cnt_q  <= cnt + 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (frames.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q  <= byte_val;
			frame_end_q <= end_val;
			run_last_q  <= job_last;
		end
	end

	assign frames.valid     = out_valid_q;
	assign frames.out_byte  = out_byte_q;
	assign frames.frame_end = frame_end_q;
	assign frames.run_last  = run_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/firmware_image_packet_framer.sv =====
// Firmware image packet framer: top level with the configuration register.
// Depends on fipf_pkg, fipf_if, fipf_front, fipf_queue and fipf_back.
//
// Usage:
//   items  : request channel. req_type 0 emits the 20-byte start frame and restarts
//            framing; req_type 1 carries the next image byte in image_byte.
//   frames : byte channel. One out_byte per cycle while ready; frame_end marks the
//            last checksum byte of a frame, run_last the last byte caused by one request.
//   APB    : one register, image_size at address 0. Write it only while idle.
// Path: a taken request is queued as a job; its bytes leave via the output register.
// Throughput: the output emits one byte per cycle while frames.ready is high.
//   A request causes one byte for a plain payload byte, eleven with a packet header,
//   more with a trailer or an empty packet (up to nineteen), twenty for a start
//   request. A byte past the image size emits nothing, save the first at size zero:
//   an empty packet. A four-entry job queue lets requests arrive while bursts drain.
// Reset: image_size, all framing state, the queue pointers and output valid clear.
// Stall: when frames.ready is low the output byte holds; the queue fills and then
//   items.ready drops until the receiver takes bytes again.
`default_nettype none

module firmware_image_packet_framer (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	fipf_req_if.sink                             items,
	fipf_out_if.source                           frames,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [fipf_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                     pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	logic [30:0]         image_size_q;
	logic                push;
	logic                pop;
	logic                q_empty;
	logic                q_full;
	fipf_pkg::fipf_job_t wr_job;
	fipf_pkg::fipf_job_t head;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == fipf_pkg::ADDR_IMAGE_SIZE) ? {1'b0, image_size_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= '0;
		end else if (psel && penable && pwrite && (paddr == fipf_pkg::ADDR_IMAGE_SIZE)) begin
			image_size_q <= pwdata[30:0];
		end
	end

	fipf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.image_size (image_size_q),
		.q_full     (q_full),
		.push       (push),
		.job        (wr_job)
	);

	fipf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.head   (head),
		.empty  (q_empty),
		.full   (q_full)
	);

	fipf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.frames  (frames)
	);

endmodule

`default_nettype wire
